[rtl/rat_pkg.sv]
// Shared types, codes and default sizes for the row activation tracker table.
package rat_pkg;

    localparam int TABLE_ENTRIES_DEF  = 16;
    localparam int RANKS_DEF          = 4;
    localparam int BANKS_PER_RANK_DEF = 16;
    localparam int ROW_BITS_DEF       = 17;
    localparam int COUNT_BITS_DEF     = 16;

    localparam logic [1:0] MODE_OTHER = 2'd0;
    localparam logic [1:0] MODE_ACT   = 2'd1;
    localparam logic [1:0] MODE_RFM   = 2'd2;
    localparam logic [1:0] MODE_RSVD  = 2'd3;

    localparam logic CFG_USE_BANK_GROUPS = 1'b0;
    localparam logic CFG_BANKS_PER_GROUP = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  rank;
        logic [2:0]  bank_group;
        logic [3:0]  bank;
        logic [16:0] row;
    } in_t;

    typedef struct packed {
        logic        hit;
        logic        evicted;
        logic [16:0] evicted_row;
        logic        max_valid;
        logic [16:0] max_row;
        logic [15:0] max_count;
        logic        bad_bank;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_MAXLD,
        ST_SCAN,
        ST_UPDATE,
        ST_FINISH
    } state_t;

endpackage

[rtl/rat_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/row_activation_tracker_table.sv]
// Top level of the row activation tracker table: per-bank counters and max tracking.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  in      | input     | in_valid/in_ready  | in_data  (mode,rank,bg,bank,row)
//  out     | output    | out_valid/out_ready| out_data (hit,evict,max,bad)
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// An activate, or a refresh management to a non-empty table, passes through
// lookup, max load, scan, update and finish before its result is presented,
// with one entry RAM read per cycle while the scan unit walks the addressed table;
// the next input transfer can be accepted in the same cycle that the result appears.
// Other commands and empty-table refreshes skip the scan and update, bad addresses the max load too.
// Entry valid words live in a RAM; a per-table written flag, cleared by reset,
// makes a never-written table read as empty, so there is no clearing pass.
// A stalled result holds in the output register; the block takes one more
// transfer, then waits with its result staged and the input side not ready.
module row_activation_tracker_table #(
    parameter int TABLE_ENTRIES  = rat_pkg::TABLE_ENTRIES_DEF,
    parameter int RANKS          = rat_pkg::RANKS_DEF,
    parameter int BANKS_PER_RANK = rat_pkg::BANKS_PER_RANK_DEF,
    parameter int ROW_BITS       = rat_pkg::ROW_BITS_DEF,
    parameter int COUNT_BITS     = rat_pkg::COUNT_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rat_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output rat_pkg::out_t out_data,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [4:0]    cfg_data
);

    import rat_pkg::*;

    localparam int NT  = RANKS * BANKS_PER_RANK;
    localparam int TW  = (NT > 1) ? $clog2(NT) : 1;
    localparam int EW  = $clog2(TABLE_ENTRIES);
    localparam int NE  = NT * TABLE_ENTRIES;
    localparam int AW  = $clog2(NE);
    localparam int DW  = ROW_BITS + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    state_t state_reg, state_next;

    // configuration
    logic       use_bg_reg;
    logic [4:0] bpg_reg;

    // per-table written flags; a clear flag means the table reads as empty
    logic [NT-1:0]            tbl_init_reg;
    logic [TABLE_ENTRIES-1:0] vrow_reg;

    // latched command
    logic [1:0]          mode_reg;
    logic [1:0]          rank_reg;
    logic [8:0]          flat_reg;
    logic                bad_reg;
    logic [ROW_BITS-1:0] row_reg;
    logic [TW-1:0]       t_reg;

    // current table maximum
    logic                  mx_v_reg;
    logic [ROW_BITS-1:0]   mx_row_reg;
    logic [COUNT_BITS-1:0] mx_cnt_reg;

    // scan state
    logic [EW:0]           iss_reg;
    logic [EW-1:0]         proc_idx_reg;
    logic                  proc_vld_reg;
    logic                  hit_f_reg;
    logic [EW-1:0]         hit_idx_reg;
    logic [COUNT_BITS-1:0] hit_cnt_reg;
    logic [EW-1:0]         min_idx_reg;
    logic [ROW_BITS-1:0]   min_row_reg;
    logic [COUNT_BITS-1:0] min_cnt_reg;
    logic                  nm_v_reg;
    logic [ROW_BITS-1:0]   nm_row_reg;
    logic [COUNT_BITS-1:0] nm_cnt_reg;

    out_t res_reg;
    out_t out_reg;
    logic out_valid_reg;

    // RAM ports
    logic          ent_we;
    logic [AW-1:0] ent_waddr, ent_raddr;
    logic [DW-1:0] ent_wdata, ent_rdata;
    logic          max_we;
    logic [TW-1:0] max_addr;
    logic [DW-1:0] max_wdata, max_rdata;
    logic                     vld_we;
    logic [TABLE_ENTRIES-1:0] vld_wdata, vld_rdata;
    logic [TABLE_ENTRIES-1:0] vrow_rd;
    logic                     mv_rd;

    logic [8:0]            flat_in;
    logic                  bad_in;
    logic [TW-1:0]         t_calc;
    logic [AW-1:0]         base;
    logic [ROW_BITS-1:0]   d_row;
    logic [COUNT_BITS-1:0] d_cnt;
    logic                  d_v;

    // update-cycle decisions
    logic                     free_found;
    logic [EW-1:0]            free_idx;
    logic [COUNT_BITS-1:0]    newc;
    logic                     u_set, u_clr;
    logic [EW-1:0]            u_vidx;
    logic                     u_hit, u_ev;
    logic [ROW_BITS-1:0]      u_ev_row;
    logic                     u_mv;
    logic [ROW_BITS-1:0]      u_mrow;
    logic [COUNT_BITS-1:0]    u_mcnt;
    logic                     scan_last;

    function automatic out_t make_res(
        input logic                  hit,
        input logic                  ev,
        input logic [ROW_BITS-1:0]   ev_row,
        input logic                  mv,
        input logic [ROW_BITS-1:0]   mrow,
        input logic [COUNT_BITS-1:0] mcnt
    );
        out_t r;
        r.hit         = hit;
        r.evicted     = ev;
        r.evicted_row = ev ? 17'({32'b0, ev_row}) : 17'b0;
        r.max_valid   = mv;
        r.max_row     = mv ? 17'({32'b0, mrow}) : 17'b0;
        r.max_count   = mv ? 16'({32'b0, mcnt}) : 16'b0;
        r.bad_bank    = 1'b0;
        return r;
    endfunction

    // flat bank index and range check on the incoming transfer
    always_comb
    begin
        flat_in = use_bg_reg ? (9'(in_data.bank_group) * 9'(bpg_reg) + 9'(in_data.bank))
                             : 9'(in_data.bank);
        bad_in  = (32'(in_data.rank) >= RANKS) || (32'(flat_in) >= BANKS_PER_RANK);
    end

    assign t_calc    = TW'(32'(rank_reg) * BANKS_PER_RANK + 32'(flat_reg));
    assign base      = AW'(t_reg) * AW'(TABLE_ENTRIES);
    assign d_row     = ent_rdata[DW-1:COUNT_BITS];
    assign d_cnt     = ent_rdata[COUNT_BITS-1:0];
    assign d_v       = vrow_reg[proc_idx_reg];
    assign scan_last = proc_vld_reg && (proc_idx_reg == EW'(TABLE_ENTRIES - 1));
    // a table holds a maximum exactly when it holds any entry
    assign vrow_rd   = tbl_init_reg[t_reg] ? vld_rdata : '0;
    assign mv_rd     = |vrow_rd;

    rat_ram #(.WIDTH(DW), .DEPTH(NE)) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    rat_ram #(.WIDTH(DW), .DEPTH(NT)) u_max_ram (
        .clk   (clk),
        .we    (max_we),
        .waddr (t_reg),
        .wdata (max_wdata),
        .raddr (max_addr),
        .rdata (max_rdata)
    );

    rat_ram #(.WIDTH(TABLE_ENTRIES), .DEPTH(NT)) u_vld_ram (
        .clk   (clk),
        .we    (vld_we),
        .waddr (t_reg),
        .wdata (vld_wdata),
        .raddr (max_addr),
        .rdata (vld_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = bad_reg ? ST_FINISH : ST_MAXLD;
            end
            ST_MAXLD:
            begin
                if (mode_reg == MODE_ACT || (mode_reg == MODE_RFM && mv_rd))
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // handshake and RAM read addressing
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        max_addr  = (state_reg == ST_LOOKUP) ? t_calc : t_reg;
        ent_raddr = (state_reg == ST_MAXLD) ? base : base + AW'(iss_reg[EW-1:0]);
    end

    // table update decisions for the update state of an activate or refresh
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!vrow_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = EW'(i);
            end
        end
        newc      = (hit_cnt_reg == CNT_MAX) ? hit_cnt_reg : hit_cnt_reg + CNT_ONE;
        u_set     = 1'b0;
        u_clr     = 1'b0;
        u_vidx    = '0;
        u_hit     = 1'b0;
        u_ev      = 1'b0;
        u_ev_row  = '0;
        u_mv      = mx_v_reg;
        u_mrow    = mx_row_reg;
        u_mcnt    = mx_cnt_reg;
        ent_we    = 1'b0;
        ent_waddr = base;
        ent_wdata = '0;
        if (state_reg == ST_UPDATE)
        begin
            if (mode_reg == MODE_ACT)
            begin
                ent_we = 1'b1;
                if (hit_f_reg)
                begin
                    u_hit     = 1'b1;
                    ent_waddr = base + AW'(hit_idx_reg);
                    ent_wdata = {row_reg, newc};
                    if (!mx_v_reg || newc > mx_cnt_reg)
                    begin
                        u_mv   = 1'b1;
                        u_mrow = row_reg;
                        u_mcnt = newc;
                    end
                    else if (mx_row_reg == row_reg)
                    begin
                        u_mcnt = newc;
                    end
                end
                else if (free_found)
                begin
                    u_set     = 1'b1;
                    u_vidx    = free_idx;
                    ent_waddr = base + AW'(free_idx);
                    ent_wdata = {row_reg, CNT_ONE};
                    if (!mx_v_reg)
                    begin
                        u_mv   = 1'b1;
                        u_mrow = row_reg;
                        u_mcnt = CNT_ONE;
                    end
                end
                else
                begin
                    // full table: take over the least-activated entry, keep its count
                    u_ev      = 1'b1;
                    u_ev_row  = min_row_reg;
                    ent_waddr = base + AW'(min_idx_reg);
                    ent_wdata = {row_reg, min_cnt_reg};
                    if (mx_v_reg && mx_row_reg == min_row_reg)
                    begin
                        u_mrow = row_reg;
                    end
                end
            end
            else
            begin
                u_clr  = hit_f_reg;
                u_vidx = hit_idx_reg;
                u_mv   = nm_v_reg;
                u_mrow = nm_row_reg;
                u_mcnt = nm_cnt_reg;
            end
        end
        vld_wdata = vrow_reg;
        if (u_set)
        begin
            vld_wdata[u_vidx] = 1'b1;
        end
        if (u_clr)
        begin
            vld_wdata[u_vidx] = 1'b0;
        end
        vld_we    = (state_reg == ST_UPDATE);
        max_we    = (state_reg == ST_UPDATE);
        max_wdata = {u_mrow, u_mcnt};
    end

    // control state, configuration, table written flags and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            use_bg_reg    <= 1'b1;
            bpg_reg       <= 5'd4;
            tbl_init_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_USE_BANK_GROUPS: use_bg_reg <= cfg_data[0];
                    CFG_BANKS_PER_GROUP: bpg_reg    <= cfg_data;
                    default:             bpg_reg    <= bpg_reg;
                endcase
            end
            if (state_reg == ST_UPDATE)
            begin
                tbl_init_reg[t_reg] <= 1'b1;
            end
            if (state_reg == ST_FINISH && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath: command latch, scan unit, result staging
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                mode_reg <= in_data.mode;
                rank_reg <= in_data.rank;
                flat_reg <= flat_in;
                bad_reg  <= bad_in;
                row_reg  <= ROW_BITS'({15'b0, in_data.row});
            end
            ST_LOOKUP:
            begin
                t_reg   <= t_calc;
                res_reg <= '{bad_bank: 1'b1, default: '0};
            end
            ST_MAXLD:
            begin
                mx_v_reg     <= mv_rd;
                mx_row_reg   <= max_rdata[DW-1:COUNT_BITS];
                mx_cnt_reg   <= max_rdata[COUNT_BITS-1:0];
                vrow_reg     <= vrow_rd;
                res_reg      <= make_res(1'b0, 1'b0, '0, mv_rd,
                                         max_rdata[DW-1:COUNT_BITS],
                                         max_rdata[COUNT_BITS-1:0]);
                iss_reg      <= (EW + 1)'(1);
                proc_idx_reg <= '0;
                proc_vld_reg <= 1'b1;
                hit_f_reg    <= 1'b0;
                nm_v_reg     <= 1'b0;
            end
            ST_SCAN:
            begin
                // advance the read stream one entry
                if (iss_reg < (EW + 1)'(TABLE_ENTRIES))
                begin
                    iss_reg      <= iss_reg + (EW + 1)'(1);
                    proc_idx_reg <= iss_reg[EW-1:0];
                    proc_vld_reg <= 1'b1;
                end
                else
                begin
                    proc_vld_reg <= 1'b0;
                end
                if (proc_vld_reg)
                begin
                    if (mode_reg == MODE_ACT)
                    begin
                        if (d_v && d_row == row_reg && !hit_f_reg)
                        begin
                            hit_f_reg   <= 1'b1;
                            hit_idx_reg <= proc_idx_reg;
                            hit_cnt_reg <= d_cnt;
                        end
                        if (proc_idx_reg == '0 || d_cnt < min_cnt_reg)
                        begin
                            min_idx_reg <= proc_idx_reg;
                            min_row_reg <= d_row;
                            min_cnt_reg <= d_cnt;
                        end
                    end
                    else
                    begin
                        // first copy of the max row is dropped; rescan the rest
                        if (d_v && d_row == mx_row_reg && !hit_f_reg)
                        begin
                            hit_f_reg   <= 1'b1;
                            hit_idx_reg <= proc_idx_reg;
                        end
                        else if (d_v && (!nm_v_reg || d_cnt > nm_cnt_reg))
                        begin
                            nm_v_reg   <= 1'b1;
                            nm_row_reg <= d_row;
                            nm_cnt_reg <= d_cnt;
                        end
                    end
                end
            end
            ST_UPDATE:
            begin
                res_reg <= make_res(u_hit, u_ev, u_ev_row, u_mv, u_mrow, u_mcnt);
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_reg <= res_reg;
                end
            end
            default:
            begin
                out_reg <= out_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input ready while an item is in flight");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.hit && out_data.evicted))
        else $error("result both hit and evicted");

    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.bad_bank) |-> (!out_data.hit && !out_data.max_valid))
        else $error("bad bank result carries table data");

endmodule
